FILE: design/rmj_pkg.sv
package rmj_pkg;

  localparam int DW        = 32;
  localparam int FB        = 16;
  localparam int MAG_W     = DW;
  localparam int SQ_W      = 2 * DW;
  localparam int R_W       = DW;
  localparam int R3_W      = 3 * DW;
  localparam int Q_W       = DW;
  localparam int LIMIT_W   = 32;
  localparam int OFFSET_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_ZERO_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUDGE_OFFSET    = CFG_IDX_W'(1);

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(429497);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(7);

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] vel_x;
    logic signed [DW-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] range_dx;
    logic signed [DW-1:0] range_dy;
    logic signed [DW-1:0] bearing_dx;
    logic signed [DW-1:0] bearing_dy;
    logic signed [DW-1:0] rate_dx;
    logic signed [DW-1:0] rate_dy;
    logic                 nudged;
    logic                 saturated;
  } out_t;

  // Sign-magnitude state after the nudge, with squared range and cross term.
  typedef struct packed {
    logic             px_neg;
    logic             py_neg;
    logic [MAG_W-1:0] px_mag;
    logic [MAG_W-1:0] py_mag;
    logic             cm_neg;
    logic [SQ_W-1:0]  cm_mag;
    logic [SQ_W-1:0]  r2;
    logic             nudged;
    logic             zero;
  } front_t;

  typedef struct packed {
    logic px_neg;
    logic py_neg;
    logic cm_neg;
    logic nudged;
    logic zero;
  } side_t;

endpackage

FILE: design/rmj_front.sv
module rmj_front import rmj_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  in_t                 in_data,
  input  logic [LIMIT_W-1:0]  near_zero_limit,
  input  logic [OFFSET_W-1:0] nudge_offset,
  output logic                out_valid,
  output front_t              out_data
);

  function automatic logic [MAG_W-1:0] mag_of(input logic [DW-1:0] v);
    return v[DW-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
  endfunction

  // Returns {neg, mag} of a sign-magnitude value plus the offset.
  function automatic logic [MAG_W:0] plus_off(input logic neg, input logic [MAG_W-1:0] mag,
                                              input logic [OFFSET_W-1:0] off);
    logic [MAG_W-1:0] off_w;
    off_w = MAG_W'(off);
    if (!neg) return {1'b0, mag + off_w};
    else if (mag > off_w) return {1'b1, mag - off_w};
    else return {1'b0, off_w - mag};
  endfunction

  logic [3:0] vld;

  // Stage 1: magnitudes.
  logic             px_n1, py_n1, vx_n1, vy_n1;
  logic [MAG_W-1:0] px_m1, py_m1, vx_m1, vy_m1;
  // Stage 2: first squares.
  logic             px_n2, py_n2, vx_n2, vy_n2;
  logic [MAG_W-1:0] px_m2, py_m2, vx_m2, vy_m2;
  logic [SQ_W-1:0]  px2_2, py2_2;
  // Stage 3: nudged positions.
  logic             px_n3, py_n3, vx_n3, vy_n3, nudged3;
  logic [MAG_W-1:0] px_m3, py_m3, vx_m3, vy_m3;
  // Stage 4: final squares and cross products.
  logic             px_n4, py_n4, an4, bn4, nudged4;
  logic [MAG_W-1:0] px_m4, py_m4;
  logic [SQ_W-1:0]  px2_4, py2_4, a4, b4;

  logic [SQ_W-1:0]  r2_first;
  logic             near;
  logic [MAG_W:0]   px_off, py_off;
  logic [SQ_W-1:0]  r2_final;

  always_comb begin
    r2_first = px2_2 + py2_2;
    near     = r2_first < SQ_W'(near_zero_limit);
    px_off   = plus_off(px_n2, px_m2, nudge_offset);
    py_off   = plus_off(py_n2, py_m2, nudge_offset);
    r2_final = px2_4 + py2_4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_n1 <= in_data.pos_x[DW-1];
      py_n1 <= in_data.pos_y[DW-1];
      vx_n1 <= in_data.vel_x[DW-1];
      vy_n1 <= in_data.vel_y[DW-1];
      px_m1 <= mag_of(in_data.pos_x);
      py_m1 <= mag_of(in_data.pos_y);
      vx_m1 <= mag_of(in_data.vel_x);
      vy_m1 <= mag_of(in_data.vel_y);

      px_n2 <= px_n1;
      py_n2 <= py_n1;
      vx_n2 <= vx_n1;
      vy_n2 <= vy_n1;
      px_m2 <= px_m1;
      py_m2 <= py_m1;
      vx_m2 <= vx_m1;
      vy_m2 <= vy_m1;
      px2_2 <= px_m1 * px_m1;
      py2_2 <= py_m1 * py_m1;

      if (near) begin
        px_n3 <= px_off[MAG_W];
        px_m3 <= px_off[MAG_W-1:0];
        py_n3 <= py_off[MAG_W];
        py_m3 <= py_off[MAG_W-1:0];
      end else begin
        px_n3 <= px_n2;
        px_m3 <= px_m2;
        py_n3 <= py_n2;
        py_m3 <= py_m2;
      end
      nudged3 <= near;
      vx_n3   <= vx_n2;
      vy_n3   <= vy_n2;
      vx_m3   <= vx_m2;
      vy_m3   <= vy_m2;

      px_n4   <= px_n3;
      py_n4   <= py_n3;
      px_m4   <= px_m3;
      py_m4   <= py_m3;
      nudged4 <= nudged3;
      px2_4   <= px_m3 * px_m3;
      py2_4   <= py_m3 * py_m3;
      a4      <= vx_m3 * py_m3;
      b4      <= vy_m3 * px_m3;
      an4     <= vx_n3 ^ py_n3;
      bn4     <= vy_n3 ^ px_n3;

      out_data.px_neg <= px_n4;
      out_data.py_neg <= py_n4;
      out_data.px_mag <= px_m4;
      out_data.py_mag <= py_m4;
      out_data.r2     <= r2_final;
      out_data.zero   <= r2_final == '0;
      out_data.nudged <= nudged4;
      // Cross term vx*py - vy*px as sign and magnitude.
      if (an4 != bn4) begin
        out_data.cm_mag <= a4 + b4;
        out_data.cm_neg <= an4;
      end else if (a4 >= b4) begin
        out_data.cm_mag <= a4 - b4;
        out_data.cm_neg <= an4;
      end else begin
        out_data.cm_mag <= b4 - a4;
        out_data.cm_neg <= !an4;
      end
    end
  end

endmodule

FILE: design/rmj_sqrt.sv
module rmj_sqrt import rmj_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] rad,
  output logic [R_W-1:0]  root
);

  localparam int REM_W = R_W + 3;

  logic [REM_W-1:0] rem_q  [1:R_W];
  logic [R_W-1:0]   root_q [1:R_W];
  logic [SQ_W-1:0]  rad_q  [1:R_W];

  // One result bit per stage, two radicand bits consumed per stage.
  for (genvar k = 0; k < R_W; k++) begin : g_step
    logic [REM_W-1:0] rem_in;
    logic [R_W-1:0]   root_in;
    logic [SQ_W-1:0]  rad_in;
    logic [REM_W-1:0] t, trial, diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
      assign rad_in  = rad_q[k];
    end

    always_comb begin
      t     = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
      trial = REM_W'({root_in, 2'b01});
      diff  = t - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= trial) begin
          rem_q[k+1]  <= diff;
          root_q[k+1] <= {root_in[R_W-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= t;
          root_q[k+1] <= {root_in[R_W-2:0], 1'b0};
        end
        rad_q[k+1] <= {rad_in[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[R_W];

endmodule

FILE: design/rmj_div.sv
module rmj_div import rmj_pkg::*; #(
  parameter int NUM_W = SQ_W,
  parameter int DEN_W = R_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [CMP_W-1:0] hi_ext, den_ext;

  logic [DEN_W-1:0] rem_q [0:Q_W];
  logic [DEN_W-1:0] dv_q  [0:Q_W];
  logic [Q_W-1:0]   low_q [0:Q_W];
  logic [Q_W-1:0]   qt_q  [0:Q_W];
  logic             ov_q  [0:Q_W];

  assign hi_ext  = CMP_W'(num[NUM_W-1:Q_W]);
  assign den_ext = CMP_W'(den);

  // The quotient needs Q_W bits unless the top part already reaches the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= hi_ext[DEN_W-1:0];
      dv_q[0]  <= den;
      low_q[0] <= num[Q_W-1:0];
      qt_q[0]  <= '0;
      ov_q[0]  <= hi_ext >= den_ext;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] trial, diff;

    always_comb begin
      trial = {rem_q[k], low_q[k][Q_W-1]};
      diff  = trial - {1'b0, dv_q[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DEN_W]) begin
          rem_q[k+1] <= diff[DEN_W-1:0];
          qt_q[k+1]  <= {qt_q[k][Q_W-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= trial[DEN_W-1:0];
          qt_q[k+1]  <= {qt_q[k][Q_W-2:0], 1'b0};
        end
        dv_q[k+1]  <= dv_q[k];
        low_q[k+1] <= {low_q[k][Q_W-2:0], 1'b0};
        ov_q[k+1]  <= ov_q[k];
      end
    end
  end

  assign quo = qt_q[Q_W];
  assign ovf = ov_q[Q_W];

endmodule

FILE: design/rmj_delay.sv
module rmj_delay import rmj_pkg::*; #(
  parameter int WIDTH = SQ_W,
  parameter int DEPTH = R_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        dat[i] <= dat[i-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = dat[DEPTH-1];

endmodule

FILE: design/radar_measurement_jacobian.sv
// Channel  Handshake                 Payload
// -------  ------------------------  ----------------------------------------
// in       in_valid / in_ready       in_data  (pos_x, pos_y, vel_x, vel_y)
// out      out_valid / out_ready     out_data (six Jacobian entries, flags)
// config   cfg_we                    cfg_index, cfg_data
//
// One beat enters per cycle when nothing stalls; beats leave in arrival order.
// The pipeline includes the 32-stage square root and the 33-stage dividers.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits and loads the register defaults; no memory to clear.
module radar_measurement_jacobian import rmj_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HALF = SQ_W / 2;

  function automatic logic [DW:0] finish(input logic [Q_W-1:0] q, input logic ovf,
                                         input logic neg);
    logic [Q_W-1:0] lim;
    logic           clip;
    lim  = neg ? Q_W'(SAT_MIN) : Q_W'(SAT_MAX);
    clip = ovf || (q > lim);
    if (clip) return {1'b1, neg ? SAT_MIN : SAT_MAX};
    return {1'b0, neg ? (~q + 1'b1) : q};
  endfunction

  logic                en;
  logic [LIMIT_W-1:0]  near_zero_limit;
  logic [OFFSET_W-1:0] nudge_offset;

  logic        f_valid, g_valid;
  front_t      f_data, g_data;
  logic [R_W-1:0] r_s;

  // Multiply stage.
  logic            m1_v;
  front_t          m1_f;
  logic [R_W-1:0]  m1_r;
  logic [SQ_W-1:0] p_r2lo, p_r2hi, p_ylo, p_yhi, p_xlo, p_xhi;

  // Sum stage.
  logic            m2_v;
  side_t           m2_side;
  logic [MAG_W-1:0] m2_px, m2_py;
  logic [R_W-1:0]  m2_r;
  logic [SQ_W-1:0] m2_r2;
  logic [R3_W-1:0] den3, ny, nx;

  logic [Q_W-1:0] q0, q1, q2, q3, q4, q5;
  logic           o0, o1, o2, o3, o4, o5;
  logic           e_valid;
  side_t          e_side;
  logic [DW:0]    res0, res1, res2, res3, res4, res5;
  out_t           nxt;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= LIMIT_RESET;
      nudge_offset    <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEAR_ZERO_LIMIT: near_zero_limit <= cfg_data[LIMIT_W-1:0];
        CFG_NUDGE_OFFSET:    nudge_offset    <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  rmj_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .near_zero_limit(near_zero_limit),
    .nudge_offset   (nudge_offset),
    .out_valid      (f_valid),
    .out_data       (f_data)
  );

  rmj_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .rad (f_data.r2),
    .root(r_s)
  );

  rmj_delay #(.WIDTH($bits(front_t)), .DEPTH(R_W)) u_sqrt_align (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .in_data  (f_data),
    .out_valid(g_valid),
    .out_data (g_data)
  );

  // Wide products are split into 32-bit halves and summed in the sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (en) begin
      m1_v <= g_valid;
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_f   <= g_data;
      m1_r   <= r_s;
      p_r2lo <= g_data.r2[HALF-1:0] * r_s;
      p_r2hi <= g_data.r2[SQ_W-1:HALF] * r_s;
      p_ylo  <= g_data.cm_mag[HALF-1:0] * g_data.py_mag;
      p_yhi  <= g_data.cm_mag[SQ_W-1:HALF] * g_data.py_mag;
      p_xlo  <= g_data.cm_mag[HALF-1:0] * g_data.px_mag;
      p_xhi  <= g_data.cm_mag[SQ_W-1:HALF] * g_data.px_mag;

      m2_side.px_neg <= m1_f.px_neg;
      m2_side.py_neg <= m1_f.py_neg;
      m2_side.cm_neg <= m1_f.cm_neg;
      m2_side.nudged <= m1_f.nudged;
      m2_side.zero   <= m1_f.zero;
      m2_px <= m1_f.px_mag;
      m2_py <= m1_f.py_mag;
      m2_r  <= m1_r;
      m2_r2 <= m1_f.r2;
      den3  <= {p_r2hi, {HALF{1'b0}}} + R3_W'(p_r2lo);
      ny    <= {p_yhi, {HALF{1'b0}}} + R3_W'(p_ylo);
      nx    <= {p_xhi, {HALF{1'b0}}} + R3_W'(p_xlo);
    end
  end

  rmj_div #(.NUM_W(MAG_W + FB), .DEN_W(R_W)) u_div_rx (
    .clk(clk), .en(en), .num({m2_px, {FB{1'b0}}}), .den(m2_r), .quo(q0), .ovf(o0)
  );

  rmj_div #(.NUM_W(MAG_W + FB), .DEN_W(R_W)) u_div_ry (
    .clk(clk), .en(en), .num({m2_py, {FB{1'b0}}}), .den(m2_r), .quo(q1), .ovf(o1)
  );

  rmj_div #(.NUM_W(MAG_W + 2 * FB), .DEN_W(SQ_W)) u_div_bx (
    .clk(clk), .en(en), .num({m2_py, {(2 * FB){1'b0}}}), .den(m2_r2), .quo(q2), .ovf(o2)
  );

  rmj_div #(.NUM_W(MAG_W + 2 * FB), .DEN_W(SQ_W)) u_div_by (
    .clk(clk), .en(en), .num({m2_px, {(2 * FB){1'b0}}}), .den(m2_r2), .quo(q3), .ovf(o3)
  );

  rmj_div #(.NUM_W(R3_W + FB), .DEN_W(R3_W)) u_div_vx (
    .clk(clk), .en(en), .num({ny, {FB{1'b0}}}), .den(den3), .quo(q4), .ovf(o4)
  );

  rmj_div #(.NUM_W(R3_W + FB), .DEN_W(R3_W)) u_div_vy (
    .clk(clk), .en(en), .num({nx, {FB{1'b0}}}), .den(den3), .quo(q5), .ovf(o5)
  );

  rmj_delay #(.WIDTH($bits(side_t)), .DEPTH(Q_W + 1)) u_div_align (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m2_v),
    .in_data  (m2_side),
    .out_valid(e_valid),
    .out_data (e_side)
  );

  always_comb begin
    res0 = finish(q0, o0, e_side.px_neg);
    res1 = finish(q1, o1, e_side.py_neg);
    res2 = finish(q2, o2, !e_side.py_neg);
    res3 = finish(q3, o3, e_side.px_neg);
    res4 = finish(q4, o4, e_side.py_neg != e_side.cm_neg);
    res5 = finish(q5, o5, e_side.px_neg == e_side.cm_neg);

    nxt.nudged = e_side.nudged;
    if (e_side.zero) begin
      nxt.range_dx   = '0;
      nxt.range_dy   = '0;
      nxt.bearing_dx = '0;
      nxt.bearing_dy = '0;
      nxt.rate_dx    = '0;
      nxt.rate_dy    = '0;
      nxt.saturated  = 1'b0;
    end else begin
      nxt.range_dx   = res0[DW-1:0];
      nxt.range_dy   = res1[DW-1:0];
      nxt.bearing_dx = res2[DW-1:0];
      nxt.bearing_dy = res3[DW-1:0];
      nxt.rate_dx    = res4[DW-1:0];
      nxt.rate_dy    = res5[DW-1:0];
      nxt.saturated  = res0[DW] | res1[DW] | res2[DW] | res3[DW] | res4[DW] | res5[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

  // A clipped beat carries at least one entry at a Q16.16 limit.
  a_sat_has_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.range_dx == SAT_MAX || out_data.range_dx == SAT_MIN ||
       out_data.range_dy == SAT_MAX || out_data.range_dy == SAT_MIN ||
       out_data.bearing_dx == SAT_MAX || out_data.bearing_dx == SAT_MIN ||
       out_data.bearing_dy == SAT_MAX || out_data.bearing_dy == SAT_MIN ||
       out_data.rate_dx == SAT_MAX || out_data.rate_dx == SAT_MIN ||
       out_data.rate_dy == SAT_MAX || out_data.rate_dy == SAT_MIN))
    else $error("saturated flag set with no entry at a limit");

  // Both range entries vanish only for a zero range, where everything is zero.
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_dx == '0 && out_data.range_dy == '0 |->
      out_data.bearing_dx == '0 && out_data.bearing_dy == '0 && !out_data.saturated)
    else $error("zero range entries with nonzero bearing or saturation");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

endmodule
